[sv/pct_pkg.sv]
package pct_pkg;

	localparam int POS_W       = 16;
	localparam int CNT_W       = 17;
	localparam int TOT_W       = 32;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int DIV_STEPS   = POS_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int OUT_FLD_W   = 3 + TOT_W;
	localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_START  = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_start;   // start word accepted: reset scan state, launch divide
		logic take_item;    // sample / stop / unused word accepted
		logic finish_start; // quotient ready: load target and post result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_valid;
		logic div_done;
	} status_t;

endpackage

[sv/pct_div.sv]
module pct_div
	import pct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [POS_W-1:0] dividend,
	input  logic [POS_W-1:0] divisor,
	output logic             done,
	output logic [POS_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [POS_W-1:0]     rem_q;
	logic [POS_W-1:0]     quo_q;
	logic [POS_W-1:0]     dvs_q;

	logic [POS_W:0]       rem_sh;
	logic                 ge;
	logic [POS_W:0]       rem_n;

	// restoring division, one quotient bit per cycle; divisor 0 gives all ones
	always_comb begin
		rem_sh = {rem_q, quo_q[POS_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_n  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n[POS_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/pct_ctrl.sv]
module pct_ctrl
	import pct_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	input  logic            out_ready,
	input  status_t         status,
	output logic            in_ready,
	output cmd_t            cmd
);

	state_t state_q;
	state_t state_d;
	logic   fire;

	assign fire = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire && (in_op == OP_START)) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		cmd.take_start   = 1'b0;
		cmd.take_item    = 1'b0;
		cmd.finish_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = !status.out_valid || out_ready;
				cmd.take_start = fire && (in_op == OP_START);
				cmd.take_item  = fire && (in_op != OP_START);
			end
			ST_DIV: begin
				cmd.finish_start = status.div_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/pct_dp.sv]
module pct_dp
	import pct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [OP_W-1:0]      in_op,
	input  logic [POS_W-1:0]     in_pos,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POS_W-1:0]     cfg_data,
	input  logic                 out_ready,
	output status_t              status,
	output logic                 out_valid,
	output logic                 out_level,
	output logic                 out_fired,
	output logic [TOT_W-1:0]     out_total,
	output logic                 out_active
);

	logic [POS_W-1:0] low_q, up_q, step_q;
	logic             armed_q, in_pass_q, moving_up_q, level_q;
	logic [POS_W-1:0] next_pos_q;
	logic [CNT_W-1:0] pass_cnt_q, target_q;
	logic [TOT_W-1:0] total_q;
	logic             ovalid_q, ofired_q;

	logic             div_done;
	logic [POS_W-1:0] quo;

	logic [POS_W-1:0] band_lo, band_hi;
	logic             in_band, reached, hit;
	logic             armed_d, in_pass_d, moving_up_d, level_d, fired_d;
	logic [POS_W-1:0] next_pos_d;
	logic [CNT_W-1:0] pass_cnt_d;
	logic [TOT_W-1:0] total_d;

	pct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.take_start),
		.dividend (up_q - low_q),
		.divisor  (step_q),
		.done     (div_done),
		.quotient (quo)
	);

	// sample / stop update
	always_comb begin
		band_lo     = low_q - step_q;
		band_hi     = up_q + step_q;
		in_band     = (in_pos >= band_lo) && (in_pos <= band_hi);
		reached     = moving_up_q ? (in_pos >= next_pos_q) : (in_pos <= next_pos_q);
		hit         = (pass_cnt_q <= target_q) && reached;
		armed_d     = armed_q;
		in_pass_d   = in_pass_q;
		moving_up_d = moving_up_q;
		level_d     = level_q;
		fired_d     = 1'b0;
		next_pos_d  = next_pos_q;
		pass_cnt_d  = pass_cnt_q;
		total_d     = total_q;
		case (in_op)
			OP_STOP: begin
				armed_d   = 1'b0;
				in_pass_d = 1'b0;
			end
			OP_SAMPLE: begin
				if (armed_q) begin
					if (!in_pass_q) begin
						if (in_band) begin
							in_pass_d  = 1'b1;
							pass_cnt_d = CNT_W'(1);
						end
					end else begin
						if (hit) begin
							level_d    = !level_q;
							total_d    = total_q + 1'b1;
							pass_cnt_d = pass_cnt_q + 1'b1;
							next_pos_d = moving_up_q ? (next_pos_q + step_q)
							                         : (next_pos_q - step_q);
							fired_d    = 1'b1;
						end
						if (!in_band) begin
							in_pass_d   = 1'b0;
							moving_up_d = !moving_up_q;
							next_pos_d  = moving_up_q ? up_q : low_q;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			up_q        <= '1;
			step_q      <= POS_W'(1);
			armed_q     <= 1'b0;
			in_pass_q   <= 1'b0;
			moving_up_q <= 1'b1;
			next_pos_q  <= '0;
			pass_cnt_q  <= CNT_W'(1);
			target_q    <= '0;
			level_q     <= 1'b0;
			total_q     <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOW_LIMIT: low_q  <= cfg_data;
					CFG_UP_LIMIT:  up_q   <= cfg_data;
					CFG_STEP_SIZE: step_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.take_start) begin
				pass_cnt_q  <= CNT_W'(1);
				next_pos_q  <= low_q;
				moving_up_q <= 1'b1;
				in_pass_q   <= 1'b0;
				total_q     <= '0;
				armed_q     <= 1'b1;
			end else if (cmd.take_item) begin
				armed_q     <= armed_d;
				in_pass_q   <= in_pass_d;
				moving_up_q <= moving_up_d;
				level_q     <= level_d;
				next_pos_q  <= next_pos_d;
				pass_cnt_q  <= pass_cnt_d;
				total_q     <= total_d;
			end
			if (cmd.finish_start) begin
				target_q <= {1'b0, quo} + 1'b1;
			end
			if (cmd.take_item || cmd.finish_start) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// result payload: start posts fired 0 and a cleared total
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			ofired_q <= fired_d;
		end else if (cmd.finish_start) begin
			ofired_q <= 1'b0;
		end
	end

	assign status.out_valid = ovalid_q;
	assign status.div_done  = div_done;
	assign out_valid        = ovalid_q;
	assign out_level        = level_q;
	assign out_fired        = ofired_q;
	assign out_total        = total_q;
	assign out_active       = armed_q;

endmodule

[sv/position_compare_trigger_unit.sv]
// Position-compare trigger for a back-and-forth scan. Each input word is a start,
// a stop or a 16-bit encoder position sample (kind in s_tuser), and each gives one
// result word. Samples and stops are taken one per cycle unless the result
// side stalls, and their result is registered on acceptance; a new word is taken
// while the previous result is being read out. A start runs a bit-serial divide
// of (up_limit - low_limit) by step_size for the trigger count, one quotient bit
// per cycle, and its result word is posted once the divide is done; the input
// stays blocked until then. Limits and step must be written over the cfg port
// only while the unit is idle; the block does not enforce this. The trigger
// level survives a start, the total clears.
module position_compare_trigger_unit
	import pct_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,   // 0 low_limit, 1 up_limit, 2 step_size
	input  logic [POS_W-1:0]       cfg_data,
	// input words
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [POS_W-1:0]       s_tdata,     // [15:0] position
	input  logic [OP_W-1:0]        s_tuser,     // [1:0] operation
	// result words
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata      // [0] trigger_level, [1] trigger_fired,
	                                            // [33:2] total_triggers, [34] active
);

	cmd_t             cmd;
	status_t          status;
	logic             level, fired, active;
	logic [TOT_W-1:0] total;

	pct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.out_ready (m_tready),
		.status    (status),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	pct_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_op      (s_tuser),
		.in_pos     (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (m_tready),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_level  (level),
		.out_fired  (fired),
		.out_total  (total),
		.out_active (active)
	);

	// pack result word, zero pad to whole bytes
	assign m_tdata = {{(OUT_TDATA_W - OUT_FLD_W){1'b0}}, active, total, fired, level};

endmodule

[test/pct_checker.sv]
`timescale 1ns / 1ps

// Watches the config port and both streams, keeps a cycle-free model of the
// scan state and checks every result word in order.
module pct_checker
	import pct_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [POS_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [POS_W-1:0]       s_tdata,     // [15:0] position
	input  logic [OP_W-1:0]        s_tuser,     // [1:0] operation
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,     // [0] level, [1] fired, [33:2] total, [34] active
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		logic             active;
		logic [TOT_W-1:0] total;
		logic             fired;
		logic             level;
	} trig_word_t;

	logic [POS_W-1:0] low_lim, up_lim, step_sz;
	logic             armed, in_pass, moving_up, level;
	logic [POS_W-1:0] next_pos;
	logic [CNT_W-1:0] pass_cnt, target_cnt;
	logic [TOT_W-1:0] total;
	trig_word_t       due_words[$];
	trig_word_t       got, want;

	// band edges wrap, so lo > hi gives an empty band
	function automatic logic in_band(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] lo, hi;
		lo = low_lim - step_sz;
		hi = up_lim + step_sz;
		return (pos >= lo) && (pos <= hi);
	endfunction

	task automatic report(input string what, input logic [TOT_W-1:0] seen,
			input logic [TOT_W-1:0] due);
		if (errors < 100)
			$display("%0t mismatch %s: got %0h, want %0h", $time, what, seen, due);
		errors++;
	endtask

	task automatic scan_step(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] span;
		logic             fired;
		trig_word_t       w;
		fired = 1'b0;
		case (op)
			OP_START: begin
				span = up_lim - low_lim;
				// zero step: divider saturates, giving 65536 triggers
				target_cnt = ((step_sz != '0) ? CNT_W'(span / step_sz) : CNT_W'(16'hFFFF))
					+ CNT_W'(1);
				pass_cnt   = CNT_W'(1);
				next_pos   = low_lim;
				moving_up  = 1'b1;
				in_pass    = 1'b0;
				total      = '0;
				armed      = 1'b1;
			end
			OP_STOP: begin
				armed   = 1'b0;
				in_pass = 1'b0;
			end
			OP_SAMPLE: begin
				if (armed && !in_pass) begin
					if (in_band(pos)) begin
						in_pass  = 1'b1;
						pass_cnt = CNT_W'(1);
					end
				end else if (armed) begin
					if (pass_cnt <= target_cnt &&
							(moving_up ? (pos >= next_pos) : (pos <= next_pos))) begin
						level    = !level;
						total    = total + 1'b1;
						pass_cnt = pass_cnt + 1'b1;
						next_pos = moving_up ? next_pos + step_sz : next_pos - step_sz;
						fired    = 1'b1;
					end
					if (!in_band(pos)) begin
						in_pass   = 1'b0;
						moving_up = !moving_up;
						next_pos  = moving_up ? low_lim : up_lim;
					end
				end
			end
			default: ;
		endcase
		w.active = armed;
		w.total  = total;
		w.fired  = fired;
		w.level  = level;
		due_words.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_lim    = '0;
			up_lim     = '1;
			step_sz    = POS_W'(1);
			armed      = 1'b0;
			in_pass    = 1'b0;
			moving_up  = 1'b1;
			next_pos   = '0;
			pass_cnt   = CNT_W'(1);
			target_cnt = '0;
			level      = 1'b0;
			total      = '0;
			errors     = 0;
			due_words.delete();
			pending   <= 0;
		end else begin
			// a result leaving now belongs to an earlier word, so pop first
			if (m_tvalid && m_tready) begin
				if (due_words.size() == 0) begin
					report("word with nothing due", m_tdata[TOT_W-1:0], '0);
				end else begin
					want = due_words.pop_front();
					got  = m_tdata[OUT_FLD_W-1:0];
					if (got.level !== want.level)
						report("trigger_level", TOT_W'(got.level), TOT_W'(want.level));
					if (got.fired !== want.fired)
						report("trigger_fired", TOT_W'(got.fired), TOT_W'(want.fired));
					if (got.total !== want.total)
						report("total_triggers", got.total, want.total);
					if (got.active !== want.active)
						report("active", TOT_W'(got.active), TOT_W'(want.active));
					if (m_tdata[OUT_TDATA_W-1:OUT_FLD_W] !== '0)
						report("pad bits", TOT_W'(m_tdata[OUT_TDATA_W-1:OUT_FLD_W]), '0);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOW_LIMIT: low_lim = cfg_data;
					CFG_UP_LIMIT:  up_lim  = cfg_data;
					CFG_STEP_SIZE: step_sz = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				scan_step(s_tuser, s_tdata);
			pending <= due_words.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Drives scan sequences into the trigger unit and gives the verdict.
// Each phase parks the unit, loads a new limit/step setting, arms a scan and
// then mostly sends back-and-forth sweeps that run from below the band to
// above it (or the reverse), with stops, restarts, stray samples and the
// unused code mixed in. Checking lives in pct_checker.
module tb_top;
	import pct_pkg::*;

	// code 3 has no meaning in the unit; it must be ignored like an idle sample
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int PHASES     = 12;
	localparam int RAND_ITEMS = 1560;
	// worst case per word adds up a gap, the divide and a stall; keep far clear
	localparam int CYCLE_CAP  = 600000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [POS_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [POS_W-1:0]       s_tdata = '0;       // [15:0] position
	logic [OP_W-1:0]        s_tuser = '0;       // [1:0] operation
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;            // [0] level, [1] fired, [33:2] total, [34] active

	int               errors, pending;
	int               cycles = 0;
	int               words_done = 0;
	logic             calm = 1'b0;              // no gaps and no stalls while set
	logic             scan_on = 1'b0;           // sender's own view of armed
	logic             rising = 1'b1;            // direction of the next sweep
	logic [POS_W-1:0] low_lim = '0, up_lim = '1, step_sz = POS_W'(1);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	position_compare_trigger_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	pct_checker trig_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	// Watchdog: a hang or a lost result ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: draw a stall per word, then hold tready until a word moves.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// One word on the input stream. tvalid stays up after acceptance so that
	// back-to-back words never see a low/high pair in the same step.
	task automatic put_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= pos;
		do @(posedge clk); while (!s_tready);
		// samples while disarmed and the unused code are just ignored
		if (op == OP_START || op == OP_STOP || (op == OP_SAMPLE && scan_on))
			words_done++;
		if (op == OP_START)
			scan_on = 1'b1;
		else if (op == OP_STOP)
			scan_on = 1'b0;
	endtask

	// Park the sender until every result is back; the unit is then idle
	// since every word yields exactly one result.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_limits(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] up,
			input logic [POS_W-1:0] st);
		low_lim   = lo;
		up_lim    = up;
		step_sz   = st;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOW_LIMIT;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_UP_LIMIT;
		cfg_data  <= up;
		@(posedge clk);
		cfg_index <= CFG_STEP_SIZE;
		cfg_data  <= st;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One pass across the band: starts a bit outside one edge, ends a bit
	// outside the other, with jitter so crossings skip or repeat positions.
	task automatic sweep(input int n);
		int a, b, spread, p, i;
		a = int'(low_lim) - 2 * int'(step_sz) - int'($urandom_range(1, 60));
		b = int'(up_lim) + 2 * int'(step_sz) + int'($urandom_range(1, 60));
		if (b < a)
			b += 65536;     // wrapped span: walk through the wrap point
		spread = (b - a) / n;
		for (i = 0; i < n; i++) begin
			p = a + (b - a) * i / (n - 1);
			if (spread > 1)
				p += int'($urandom_range(0, spread)) - spread / 2;
			if (!rising)
				p = a + b - p;
			put_word(OP_SAMPLE, POS_W'(p));
		end
		// now and then sweep the same way twice, against the unit's direction
		if ($urandom_range(0, 9) != 0)
			rising = !rising;
	endtask

	initial begin
		int ph, quota, pick, k;
		logic [POS_W-1:0] lo, up, st;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset limits give an empty band: nothing opens a pass
		put_word(OP_SAMPLE, 16'h0000);          // disarmed sample
		put_word(OP_UNUSED, 16'hFFFF);
		put_word(OP_STOP, 16'h0000);
		put_word(OP_START, 16'h0000);
		put_word(OP_SAMPLE, 16'h0000);
		put_word(OP_SAMPLE, 16'hFFFF);
		drain();

		// band [90, 210], triggers at 100, 110, ... going up
		set_limits(16'd100, 16'd200, 16'd10);
		put_word(OP_START, 16'h0000);
		put_word(OP_SAMPLE, 16'd95);            // opens the pass, no trigger
		put_word(OP_SAMPLE, 16'd100);
		put_word(OP_SAMPLE, 16'd125);
		put_word(OP_SAMPLE, 16'd300);           // fires and leaves: direction flips
		put_word(OP_SAMPLE, 16'd205);
		put_word(OP_SAMPLE, 16'd200);
		put_word(OP_SAMPLE, 16'd0);
		put_word(OP_START, 16'h0000);           // restart while armed
		put_word(OP_STOP, 16'h0000);
		put_word(OP_SAMPLE, 16'd150);           // after stop: ignored
		drain();

		// zero step: next position never moves, target saturates
		set_limits(16'd10, 16'd20, 16'd0);
		put_word(OP_START, 16'h0000);
		put_word(OP_SAMPLE, 16'd10);
		put_word(OP_SAMPLE, 16'd15);
		put_word(OP_SAMPLE, 16'd20);
		put_word(OP_SAMPLE, 16'd21);

		// --- random part ---
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 8)
				0: begin                        // step 1, short span: target runs out
					lo = POS_W'($urandom_range(100, 60000));
					up = lo + POS_W'($urandom_range(0, 60));
					st = 16'd1;
				end
				1: begin
					lo = POS_W'($urandom_range(0, 60000));
					up = lo + POS_W'($urandom_range(0, 3000));
					st = POS_W'($urandom_range(1, 400));
				end
				2: begin                        // full range, largest step
					lo = 16'h0000;
					up = 16'hFFFF;
					st = 16'hFFFF;
				end
				3: begin                        // low above up: wrapped span
					up = POS_W'($urandom_range(0, 30000));
					lo = up + POS_W'($urandom_range(1, 3000));
					st = POS_W'($urandom_range(1000, 20000));
				end
				4: begin                        // zero span
					lo = POS_W'($urandom_range(1000, 64000));
					up = lo;
					st = POS_W'($urandom_range(1, 100));
				end
				5: begin                        // band edges land on 0 and 65535
					st = POS_W'($urandom_range(1, 500));
					lo = st;
					up = 16'hFFFF - st;
				end
				6: begin
					lo = POS_W'($urandom_range(0, 40000));
					up = lo + POS_W'($urandom_range(0, 400));
					st = POS_W'($urandom_range(1, 40));
				end
				default: begin
					lo = POS_W'($urandom);
					up = POS_W'($urandom);
					st = POS_W'($urandom_range(1, 65535));
				end
			endcase
			set_limits(lo, up, st);
			calm   = ($urandom_range(0, 3) == 0);
			rising = 1'b1;
			put_word(OP_START, POS_W'($urandom));
			quota = words_done + RAND_ITEMS / PHASES;
			while (words_done < quota) begin
				pick = $urandom_range(0, 99);
				if (pick < 78) begin
					sweep($urandom_range(3, 40));
				end else if (pick < 86) begin
					put_word(OP_SAMPLE, POS_W'($urandom));
				end else if (pick < 90) begin
					put_word(OP_START, POS_W'($urandom));
					rising = 1'b1;
				end else if (pick < 96) begin
					put_word(OP_STOP, POS_W'($urandom));
					for (k = $urandom_range(0, 2); k > 0; k--)
						put_word(OP_SAMPLE, POS_W'($urandom));
					put_word(OP_START, POS_W'($urandom));
					rising = 1'b1;
				end else begin
					put_word(OP_UNUSED, POS_W'($urandom));
				end
			end
		end

		drain();
		repeat (25) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
